// ===== rtl/core/dlv_pkg.sv =====
// Shared types and constants for the decimal literal validator.
// No dependencies; every core file imports this package.
`default_nettype none

package dlv_pkg;

  localparam int unsigned LenW    = 13;
  localparam int unsigned CharW   = 8;

  localparam logic [LenW-1:0] LengthReset = 13'd512;
  localparam logic [LenW-1:0] LengthCap   = 13'd4096;
  localparam logic [LenW-1:0] CountMax    = 13'd8191;

  localparam logic [CharW-1:0] ChPlus  = 8'h2B;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChDot   = 8'h2E;
  localparam logic [CharW-1:0] ChLowE  = 8'h65;
  localparam logic [CharW-1:0] ChUpE   = 8'h45;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;

  typedef enum logic [3:0] {
    G_START   = 4'd0,
    G_SIGN    = 4'd1,
    G_INT     = 4'd2,
    G_DOT     = 4'd3,
    G_FRAC    = 4'd4,
    G_EXP     = 4'd5,
    G_EXPSIGN = 4'd6,
    G_EXPDIG  = 4'd7,
    G_REJECT  = 4'd8
  } grammar_e;

  typedef enum logic [1:0] {
    V_ACCEPT = 2'd0,
    V_EMPTY  = 2'd1,
    V_LONG   = 2'd2,
    V_BAD    = 2'd3
  } verdict_e;

  // One character request held in the input stage
  typedef struct packed {
    logic [CharW-1:0] char_byte;
    logic             last_char;
    logic             empty_token;
  } char_req_t;

  // Outcome of the current request
  typedef struct packed {
    logic     has_result;
    verdict_e verdict;
  } token_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/decimal_literal_validator.sv =====
// Top level of the decimal literal validator: input stage, length register,
// result register. Depends on dlv_pkg and dlv_token.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  in      | input     | in_valid_i/in_stall_o  | char_byte_i, last_char_i, empty_token_i
//  out     | output    | out_valid_o/out_stall_i| verdict_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_data_i (max_length)
//
// One character per cycle while in_stall_o is low; a verdict for a token passes
// through the input register, then the result register, to reach the output.
// Reset sets max_length to 512 and clears the grammar state and count.
// A held result stalls the input stage only when the next request also
// ends a token; characters inside a token keep flowing.
`default_nettype none

module decimal_literal_validator import dlv_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [CharW-1:0] char_byte_i,
  input  wire logic             last_char_i,
  input  wire logic             empty_token_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [1:0]            verdict_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [LenW-1:0]  cfg_data_i
);

  logic            s1_valid_q, s1_valid_d;
  char_req_t       s1_req_q;
  logic            out_valid_q, out_valid_d;
  verdict_e        verdict_q;
  logic [LenW-1:0] max_length_q;
  token_res_t      res;
  logic            out_free, s1_go, in_acc;

  // Stage handshake
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign s1_go      = s1_valid_q & (~res.has_result | out_free);
  assign in_stall_o = s1_valid_q & ~s1_go;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign s1_valid_d = in_acc | (s1_valid_q & ~s1_go);

  // Load a result or drop a taken one
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_go && res.has_result) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  dlv_token u_token (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (s1_go),
    .req_i        (s1_req_q),
    .max_length_i (max_length_q),
    .res_o        (res)
  );

  // Control registers and length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      max_length_q <= LengthReset;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        max_length_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_req_q.char_byte   <= char_byte_i;
      s1_req_q.last_char   <= last_char_i;
      s1_req_q.empty_token <= empty_token_i;
    end
    if (s1_go && res.has_result) begin
      verdict_q <= res.verdict;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

endmodule

`default_nettype wire

// ===== rtl/core/dlv_token.sv =====
// Grammar state machine and saturating length count for one token.
// Depends on dlv_pkg.
`default_nettype none

module dlv_token import dlv_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire char_req_t       req_i,
  input  wire logic [LenW-1:0] max_length_i,
  output token_res_t           res_o
);

  grammar_e        state_q, state_d, adv_state;
  logic [LenW-1:0] count_q, count_d, count_inc, limit;
  logic            is_digit, is_sign, is_exp, is_dot, tok_end;

  // Classify the character
  assign is_digit = (req_i.char_byte >= ChZero) && (req_i.char_byte <= ChNine);
  assign is_sign  = (req_i.char_byte == ChPlus) || (req_i.char_byte == ChMinus);
  assign is_exp   = (req_i.char_byte == ChLowE) || (req_i.char_byte == ChUpE);
  assign is_dot   = (req_i.char_byte == ChDot);
  assign tok_end  = req_i.empty_token | req_i.last_char;

  // Grammar transition for this character
  always_comb begin
    adv_state = G_REJECT;
    unique case (state_q) inside
      G_START: begin
        if (is_sign)       adv_state = G_SIGN;
        else if (is_digit) adv_state = G_INT;
        else if (is_dot)   adv_state = G_DOT;
      end
      G_SIGN: begin
        if (is_digit)    adv_state = G_INT;
        else if (is_dot) adv_state = G_DOT;
      end
      G_INT: begin
        if (is_digit)    adv_state = G_INT;
        else if (is_dot) adv_state = G_FRAC;
        else if (is_exp) adv_state = G_EXP;
      end
      G_DOT: begin
        if (is_digit) adv_state = G_FRAC;
      end
      G_FRAC: begin
        if (is_digit)    adv_state = G_FRAC;
        else if (is_exp) adv_state = G_EXP;
      end
      G_EXP: begin
        if (is_sign)       adv_state = G_EXPSIGN;
        else if (is_digit) adv_state = G_EXPDIG;
      end
      G_EXPSIGN, G_EXPDIG: begin
        if (is_digit) adv_state = G_EXPDIG;
      end
      default: adv_state = G_REJECT;
    endcase
  end

  // Saturate the count at its top value
  assign count_inc = (count_q == CountMax) ? count_q : count_q + 1'b1;

  // Next state: advance on a step, restart after any verdict
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    if (step_i) begin
      if (tok_end) begin
        state_d = G_START;
        count_d = '0;
      end else begin
        state_d = adv_state;
        count_d = count_inc;
      end
    end
  end

  // Verdict: empty before too long before malformed
  assign limit = (max_length_i > LengthCap) ? LengthCap : max_length_i;

  always_comb begin
    res_o.has_result = tok_end;
    if (req_i.empty_token) begin
      res_o.verdict = V_EMPTY;
    end else if (count_inc > limit) begin
      res_o.verdict = V_LONG;
    end else if (adv_state == G_INT || adv_state == G_FRAC || adv_state == G_EXPDIG) begin
      res_o.verdict = V_ACCEPT;
    end else begin
      res_o.verdict = V_BAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_START;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire
